// ===== hdl/depq_pkg.sv =====
// Shared types, codes and helpers for the double-ended priority queue.
package depq_pkg;

  localparam int unsigned DEF_CAPACITY = 256;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 48;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_POP_MAX = 2'd1,
    OP_POP_MIN = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    SIDE_MAX = 1'b0,
    SIDE_MIN = 1'b1
  } side_t;

  typedef struct packed {
    logic [15:0] pri;
    logic [15:0] tag;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROOT_RD,
    ST_ROOT_LAT,
    ST_LAST_RD,
    ST_LAST_LAT,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_RDL,
    ST_DN_RDR,
    ST_DN_LATR,
    ST_DN_CMP,
    ST_NEXT,
    ST_DONE
  } state_t;

  // True when key a must sit above key b in the heap on side s.
  function automatic logic beats(logic [15:0] a, logic [15:0] b, side_t s);
    return (s == SIDE_MAX) ? (a > b) : (a < b);
  endfunction

endpackage

// ===== hdl/depq_heap_ram.sv =====
// Storage for one heap: entry memory plus twin position memory.
module depq_heap_ram #(
  parameter int unsigned DEPTH = depq_pkg::DEF_CAPACITY,
  localparam int unsigned IDX_W = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic [IDX_W-1:0]     rd_addr,
  output depq_pkg::entry_t     rd_data,
  output logic [IDX_W-1:0]     rd_twin,
  input  logic                 d_we,
  input  logic [IDX_W-1:0]     d_addr,
  input  depq_pkg::entry_t     d_wdata,
  input  logic                 t_we,
  input  logic [IDX_W-1:0]     t_addr,
  input  logic [IDX_W-1:0]     t_wdata
);

  depq_pkg::entry_t   data_mem [DEPTH];
  logic [IDX_W-1:0]   twin_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (d_we) begin
      data_mem[d_addr] <= d_wdata;
    end
    rd_data <= data_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      twin_mem[t_addr] <= t_wdata;
    end
    rd_twin <= twin_mem[rd_addr];
  end

endmodule

// ===== hdl/double_ended_priority_queue_unit.sv =====
// Top level of the double-ended priority queue (twin max-heap / min-heap).
//
// Holds up to CAPACITY entries of (priority, tag); each transaction on the
// input stream is an insert, a pop of the highest priority or a pop of the
// lowest priority, and yields exactly one result transaction with status,
// removed priority and tag, and the occupancy afterwards. One operation is
// worked at a time by a sequencer around three key comparators and the
// two heap memories, each with one registered read port. A sift-up level
// reads the parent, then compares and moves; a sift-down level reads the
// left child, reads the right child when there is one, compares the right
// child and moves. Rejected operations (full, empty, unused code) go
// straight to the result. The input is accepted only while the sequencer
// is idle; a finished result waits in the output register and does not
// hold off the next input. Memory contents need no initialization: only
// slots below the occupancy are ever read.
module double_ended_priority_queue_unit #(
  parameter int unsigned CAPACITY = depq_pkg::DEF_CAPACITY
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [1:0] operation, [17:2] tag, [33:18] priority_req, [39:34] zero
  input  logic [depq_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [1:0] status, [17:2] removed_priority, [33:18] removed_tag,
  // [42:34] occupancy, [47:43] zero
  output logic [depq_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // Sequencer and datapath registers
  depq_pkg::state_t  state_r, state_nxt;
  depq_pkg::op_t     op_r, op_nxt;
  depq_pkg::side_t   side_r, side_nxt;
  logic              phase_r, phase_nxt;   // 0: root heap, 1: twin heap
  logic              first_r, first_nxt;   // rise may fall back to sink
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic [IDX_W-1:0]  lim_r, lim_nxt;
  logic [IDX_W-1:0]  p_r, p_nxt;
  logic [IDX_W-1:0]  fpos_r, fpos_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  depq_pkg::entry_t  e_r, e_nxt;
  logic [IDX_W-1:0]  e_twin_r, e_twin_nxt;
  depq_pkg::entry_t  ch_r, ch_nxt;
  logic [IDX_W-1:0]  ch_twin_r, ch_twin_nxt;
  logic [IDX_W-1:0]  cidx_r, cidx_nxt;
  logic [1:0]        res_status_r, res_status_nxt;
  logic [15:0]       res_pri_r, res_pri_nxt;
  logic [15:0]       res_tag_r, res_tag_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [depq_pkg::OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  // Input fields
  depq_pkg::op_t     in_op;
  logic [15:0]       in_tag;
  logic [15:0]       in_pri;

  // Memory side
  logic [IDX_W-1:0]  rd_addr;
  depq_pkg::entry_t  max_rd_data, min_rd_data, rd_data;
  logic [IDX_W-1:0]  max_rd_twin, min_rd_twin, rd_twin;
  logic              hw_en, ow_en;
  logic [IDX_W-1:0]  hw_addr, hw_twin, ow_addr, ow_twin;
  depq_pkg::entry_t  hw_data;

  // Index arithmetic and compares
  logic [IDX_W-1:0]  parent_idx;
  logic [IDX_W:0]    c_left;
  logic [IDX_W+1:0]  c_right;
  logic              left_in, right_in;
  logic              up_go, right_win, dn_go;
  logic              full, empty;

  assign in_op  = depq_pkg::op_t'(in_tdata[1:0]);
  assign in_tag = in_tdata[17:2];
  assign in_pri = in_tdata[33:18];

  assign full  = (count_r == CNT_W'(CAPACITY));
  assign empty = (count_r == '0);

  assign rd_data = (side_r == depq_pkg::SIDE_MAX) ? max_rd_data : min_rd_data;
  assign rd_twin = (side_r == depq_pkg::SIDE_MAX) ? max_rd_twin : min_rd_twin;

  assign parent_idx = (pos_r - 1'b1) >> 1;
  assign c_left     = {pos_r, 1'b1};
  assign c_right    = {1'b0, c_left} + 1'b1;
  assign left_in    = (c_left < {1'b0, lim_r});
  assign right_in   = (c_right < {2'b00, lim_r});

  assign up_go     = depq_pkg::beats(e_r.pri, rd_data.pri, side_r);
  assign right_win = depq_pkg::beats(rd_data.pri, ch_r.pri, side_r);
  assign dn_go     = depq_pkg::beats(ch_r.pri, e_r.pri, side_r);

  assign in_tready  = (state_r == depq_pkg::ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      depq_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          unique case (in_op)
            depq_pkg::OP_INSERT:  state_nxt = full ? depq_pkg::ST_DONE : depq_pkg::ST_UP_RD;
            depq_pkg::OP_POP_MAX,
            depq_pkg::OP_POP_MIN: state_nxt = empty ? depq_pkg::ST_DONE : depq_pkg::ST_ROOT_RD;
            default:              state_nxt = depq_pkg::ST_DONE;
          endcase
        end
      end
      depq_pkg::ST_ROOT_RD:  state_nxt = depq_pkg::ST_ROOT_LAT;
      depq_pkg::ST_ROOT_LAT: begin
        state_nxt = (count_r == CNT_W'(1)) ? depq_pkg::ST_DONE : depq_pkg::ST_LAST_RD;
      end
      depq_pkg::ST_LAST_RD:  state_nxt = depq_pkg::ST_LAST_LAT;
      depq_pkg::ST_LAST_LAT: begin
        state_nxt = phase_r ? depq_pkg::ST_UP_RD : depq_pkg::ST_DN_RDL;
      end
      depq_pkg::ST_UP_RD: begin
        priority if (pos_r != '0) state_nxt = depq_pkg::ST_UP_CMP;
        else if (first_r)         state_nxt = depq_pkg::ST_DN_RDL;
        else                      state_nxt = depq_pkg::ST_NEXT;
      end
      depq_pkg::ST_UP_CMP: begin
        priority if (up_go) state_nxt = depq_pkg::ST_UP_RD;
        else if (first_r)   state_nxt = depq_pkg::ST_DN_RDL;
        else                state_nxt = depq_pkg::ST_NEXT;
      end
      depq_pkg::ST_DN_RDL: begin
        state_nxt = left_in ? depq_pkg::ST_DN_RDR : depq_pkg::ST_NEXT;
      end
      depq_pkg::ST_DN_RDR: begin
        state_nxt = right_in ? depq_pkg::ST_DN_LATR : depq_pkg::ST_DN_CMP;
      end
      depq_pkg::ST_DN_LATR: state_nxt = depq_pkg::ST_DN_CMP;
      depq_pkg::ST_DN_CMP: begin
        state_nxt = dn_go ? depq_pkg::ST_DN_RDL : depq_pkg::ST_NEXT;
      end
      depq_pkg::ST_NEXT: begin
        if (op_r == depq_pkg::OP_INSERT) begin
          state_nxt = (side_r == depq_pkg::SIDE_MAX) ? depq_pkg::ST_UP_RD : depq_pkg::ST_DONE;
        end else begin
          state_nxt = (!phase_r && (p_r < lim_r)) ? depq_pkg::ST_LAST_RD : depq_pkg::ST_DONE;
        end
      end
      depq_pkg::ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = depq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = depq_pkg::ST_IDLE;
    endcase
  end

  // Memory control and datapath updates
  always_comb begin
    op_nxt         = op_r;
    side_nxt       = side_r;
    phase_nxt      = phase_r;
    first_nxt      = first_r;
    pos_nxt        = pos_r;
    lim_nxt        = lim_r;
    p_nxt          = p_r;
    fpos_nxt       = fpos_r;
    count_nxt      = count_r;
    e_nxt          = e_r;
    e_twin_nxt     = e_twin_r;
    ch_nxt         = ch_r;
    ch_twin_nxt    = ch_twin_r;
    cidx_nxt       = cidx_r;
    res_status_nxt = res_status_r;
    res_pri_nxt    = res_pri_r;
    res_tag_nxt    = res_tag_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    rd_addr        = '0;
    hw_en          = 1'b0;
    hw_addr        = pos_r;
    hw_data        = e_r;
    hw_twin        = e_twin_r;
    ow_en          = 1'b0;
    ow_addr        = e_twin_r;
    ow_twin        = pos_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      depq_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          op_nxt         = in_op;
          res_status_nxt = depq_pkg::STATUS_OK;
          res_pri_nxt    = '0;
          res_tag_nxt    = '0;
          phase_nxt      = 1'b0;
          first_nxt      = 1'b0;
          unique case (in_op)
            depq_pkg::OP_INSERT: begin
              if (full) begin
                res_status_nxt = depq_pkg::STATUS_FULL;
              end else begin
                side_nxt   = depq_pkg::SIDE_MAX;
                pos_nxt    = count_r[IDX_W-1:0];
                e_nxt.pri  = in_pri;
                e_nxt.tag  = in_tag;
                e_twin_nxt = count_r[IDX_W-1:0];
              end
            end
            depq_pkg::OP_POP_MAX,
            depq_pkg::OP_POP_MIN: begin
              side_nxt = (in_op == depq_pkg::OP_POP_MAX) ? depq_pkg::SIDE_MAX
                                                          : depq_pkg::SIDE_MIN;
              if (empty) begin
                res_status_nxt = depq_pkg::STATUS_EMPTY;
              end
            end
            default: begin
              res_status_nxt = depq_pkg::STATUS_OK;
            end
          endcase
        end
      end
      depq_pkg::ST_ROOT_RD: begin
        rd_addr = '0;
      end
      depq_pkg::ST_ROOT_LAT: begin
        res_pri_nxt = rd_data.pri;
        res_tag_nxt = rd_data.tag;
        p_nxt       = rd_twin;
        lim_nxt     = IDX_W'(count_r - 1'b1);
        if (count_r == CNT_W'(1)) begin
          count_nxt = '0;
        end
      end
      depq_pkg::ST_LAST_RD: begin
        rd_addr = lim_r;
      end
      depq_pkg::ST_LAST_LAT: begin
        e_nxt      = rd_data;
        e_twin_nxt = rd_twin;
        if (phase_r) begin
          pos_nxt   = p_r;
          first_nxt = 1'b1;
        end else begin
          pos_nxt = '0;
        end
      end
      depq_pkg::ST_UP_RD: begin
        rd_addr = parent_idx;
        if (pos_r == '0 && !first_r) begin
          // settle the moving entry at the hole
          hw_en    = 1'b1;
          ow_en    = 1'b1;
          fpos_nxt = pos_r;
        end
      end
      depq_pkg::ST_UP_CMP: begin
        if (up_go) begin
          // pull the parent down into the hole
          hw_en     = 1'b1;
          hw_data   = rd_data;
          hw_twin   = rd_twin;
          ow_en     = 1'b1;
          ow_addr   = rd_twin;
          pos_nxt   = parent_idx;
          first_nxt = 1'b0;
        end else if (!first_r) begin
          hw_en    = 1'b1;
          ow_en    = 1'b1;
          fpos_nxt = pos_r;
        end
      end
      depq_pkg::ST_DN_RDL: begin
        rd_addr = c_left[IDX_W-1:0];
        if (!left_in) begin
          hw_en    = 1'b1;
          ow_en    = 1'b1;
          fpos_nxt = pos_r;
        end
      end
      depq_pkg::ST_DN_RDR: begin
        ch_nxt      = rd_data;
        ch_twin_nxt = rd_twin;
        cidx_nxt    = c_left[IDX_W-1:0];
        rd_addr     = c_right[IDX_W-1:0];
      end
      depq_pkg::ST_DN_LATR: begin
        // the right child wins only when strictly better
        if (right_win) begin
          ch_nxt      = rd_data;
          ch_twin_nxt = rd_twin;
          cidx_nxt    = c_right[IDX_W-1:0];
        end
      end
      depq_pkg::ST_DN_CMP: begin
        if (dn_go) begin
          // lift the child into the hole
          hw_en   = 1'b1;
          hw_data = ch_r;
          hw_twin = ch_twin_r;
          ow_en   = 1'b1;
          ow_addr = ch_twin_r;
          pos_nxt = cidx_r;
        end else begin
          hw_en    = 1'b1;
          ow_en    = 1'b1;
          fpos_nxt = pos_r;
        end
      end
      depq_pkg::ST_NEXT: begin
        if (op_r == depq_pkg::OP_INSERT) begin
          if (side_r == depq_pkg::SIDE_MAX) begin
            side_nxt   = depq_pkg::SIDE_MIN;
            pos_nxt    = count_r[IDX_W-1:0];
            e_twin_nxt = fpos_r;
            first_nxt  = 1'b0;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end else begin
          if (!phase_r && (p_r < lim_r)) begin
            phase_nxt = 1'b1;
            side_nxt  = (side_r == depq_pkg::SIDE_MAX) ? depq_pkg::SIDE_MIN
                                                       : depq_pkg::SIDE_MAX;
          end else begin
            count_nxt = CNT_W'(lim_r);
          end
        end
      end
      depq_pkg::ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {5'd0, 9'(count_r), res_tag_r, res_pri_r, res_status_r};
        end
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= depq_pkg::ST_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    side_r       <= side_nxt;
    phase_r      <= phase_nxt;
    first_r      <= first_nxt;
    pos_r        <= pos_nxt;
    lim_r        <= lim_nxt;
    p_r          <= p_nxt;
    fpos_r       <= fpos_nxt;
    e_r          <= e_nxt;
    e_twin_r     <= e_twin_nxt;
    ch_r         <= ch_nxt;
    ch_twin_r    <= ch_twin_nxt;
    cidx_r       <= cidx_nxt;
    res_status_r <= res_status_nxt;
    res_pri_r    <= res_pri_nxt;
    res_tag_r    <= res_tag_nxt;
    out_tdata_r  <= out_tdata_nxt;
  end

  // Entry writes go to the working heap, twin repairs to the other heap.
  depq_heap_ram #(.DEPTH(CAPACITY)) u_max_ram (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (max_rd_data),
    .rd_twin (max_rd_twin),
    .d_we    (hw_en && (side_r == depq_pkg::SIDE_MAX)),
    .d_addr  (hw_addr),
    .d_wdata (hw_data),
    .t_we    ((side_r == depq_pkg::SIDE_MAX) ? hw_en : ow_en),
    .t_addr  ((side_r == depq_pkg::SIDE_MAX) ? hw_addr : ow_addr),
    .t_wdata ((side_r == depq_pkg::SIDE_MAX) ? hw_twin : ow_twin)
  );

  depq_heap_ram #(.DEPTH(CAPACITY)) u_min_ram (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (min_rd_data),
    .rd_twin (min_rd_twin),
    .d_we    (hw_en && (side_r == depq_pkg::SIDE_MIN)),
    .d_addr  (hw_addr),
    .d_wdata (hw_data),
    .t_we    ((side_r == depq_pkg::SIDE_MIN) ? hw_en : ow_en),
    .t_addr  ((side_r == depq_pkg::SIDE_MIN) ? hw_addr : ow_addr),
    .t_wdata ((side_r == depq_pkg::SIDE_MIN) ? hw_twin : ow_twin)
  );

endmodule

// ===== hdl/depq_checker.sv =====
// Port-level checks for the double-ended priority queue, bound to the top level.
module depq_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [depq_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // Hold a stalled result transaction.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Drop ready after an accepted input: one operation at a time.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while busy");

  // Report only defined status codes.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] == depq_pkg::STATUS_OK ||
                   out_tdata[1:0] == depq_pkg::STATUS_EMPTY ||
                   out_tdata[1:0] == depq_pkg::STATUS_FULL)
    else $error("undefined status");

  // Zero the removed fields on a rejected operation.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != depq_pkg::STATUS_OK |-> out_tdata[33:2] == '0)
    else $error("removed fields set on rejected operation");

endmodule

bind double_ended_priority_queue_unit depq_checker u_depq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the double-ended priority queue unit.
`timescale 1ns / 100ps

// Tracks the queue contents and checks each result against the expected one.
class depq_scoreboard;
  typedef struct {
    depq_pkg::status_t status;
    logic [15:0] pri;
    logic [15:0] tag;
    logic [8:0]  occ;
  } result_t;

  // Twin-heap mirror: slots of priority, tag and twin position.
  logic [15:0] mx_pri[256], mx_tag[256], mn_pri[256], mn_tag[256];
  int unsigned mx_twin[256], mn_twin[256];
  int unsigned count;
  result_t     pending[$];
  int          errors;

  function void clear();
    count = 0;
    pending.delete();
    errors = 0;
  endfunction

  function bit better(logic [15:0] a, logic [15:0] b, bit is_max);
    return is_max ? (a > b) : (a < b);
  endfunction

  // Swap slots i and j of one heap and repoint the twins in the other.
  function void swap_at(bit is_max, int unsigned i, int unsigned j);
    logic [15:0] tp, tt;
    int unsigned tw;
    if (is_max) begin
      tp = mx_pri[i]; mx_pri[i] = mx_pri[j]; mx_pri[j] = tp;
      tt = mx_tag[i]; mx_tag[i] = mx_tag[j]; mx_tag[j] = tt;
      tw = mx_twin[i]; mx_twin[i] = mx_twin[j]; mx_twin[j] = tw;
      mn_twin[mx_twin[i]] = i;
      mn_twin[mx_twin[j]] = j;
    end else begin
      tp = mn_pri[i]; mn_pri[i] = mn_pri[j]; mn_pri[j] = tp;
      tt = mn_tag[i]; mn_tag[i] = mn_tag[j]; mn_tag[j] = tt;
      tw = mn_twin[i]; mn_twin[i] = mn_twin[j]; mn_twin[j] = tw;
      mx_twin[mn_twin[i]] = i;
      mx_twin[mn_twin[j]] = j;
    end
  endfunction

  function logic [15:0] key(bit is_max, int unsigned i);
    return is_max ? mx_pri[i] : mn_pri[i];
  endfunction

  function int unsigned sift_up(bit is_max, int unsigned pos);
    int unsigned up;
    while (pos > 0) begin
      up = (pos - 1) / 2;
      if (!better(key(is_max, pos), key(is_max, up), is_max)) break;
      swap_at(is_max, pos, up);
      pos = up;
    end
    return pos;
  endfunction

  function void sink_slot(bit is_max, int unsigned pos, int unsigned n);
    int unsigned c;
    forever begin
      c = 2 * pos + 1;
      if (c >= n) break;
      if (c + 1 < n && better(key(is_max, c + 1), key(is_max, c), is_max)) c++;
      if (!better(key(is_max, c), key(is_max, pos), is_max)) break;
      swap_at(is_max, pos, c);
      pos = c;
    end
  endfunction

  // Drop slot pos by moving the last entry (index n) into it, then resettle.
  function void drop_slot(bit is_max, int unsigned pos, int unsigned n);
    if (pos >= n) return;
    if (is_max) begin
      mx_pri[pos] = mx_pri[n]; mx_tag[pos] = mx_tag[n]; mx_twin[pos] = mx_twin[n];
      mn_twin[mx_twin[pos]] = pos;
    end else begin
      mn_pri[pos] = mn_pri[n]; mn_tag[pos] = mn_tag[n]; mn_twin[pos] = mn_twin[n];
      mx_twin[mn_twin[pos]] = pos;
    end
    if (sift_up(is_max, pos) == pos) sink_slot(is_max, pos, n);
  endfunction

  function void note_op(logic [1:0] op, logic [15:0] tag, logic [15:0] pri);
    result_t r;
    int unsigned n, p;
    bit is_max;
    r.status = depq_pkg::STATUS_OK;
    r.pri = '0;
    r.tag = '0;
    if (op == depq_pkg::OP_INSERT) begin
      if (count >= 256) begin
        r.status = depq_pkg::STATUS_FULL;
      end else begin
        n = count;
        mx_pri[n] = pri; mx_tag[n] = tag; mx_twin[n] = n;
        mn_pri[n] = pri; mn_tag[n] = tag; mn_twin[n] = n;
        count = n + 1;
        void'(sift_up(1'b1, n));
        void'(sift_up(1'b0, n));
      end
    end else if (op == depq_pkg::OP_POP_MAX || op == depq_pkg::OP_POP_MIN) begin
      if (count == 0) begin
        r.status = depq_pkg::STATUS_EMPTY;
      end else begin
        is_max = (op == depq_pkg::OP_POP_MAX);
        n = count - 1;
        r.pri = key(is_max, 0);
        r.tag = is_max ? mx_tag[0] : mn_tag[0];
        p = is_max ? mx_twin[0] : mn_twin[0];
        drop_slot(is_max, 0, n);
        drop_slot(!is_max, p, n);
        count = n;
      end
    end
    r.occ = count[8:0];
    pending.push_back(r);
  endfunction

  function void check_result(logic [47:0] d);
    result_t r;
    if (pending.size() == 0) begin
      $error("result with no pending operation: %h", d);
      errors++;
      return;
    end
    r = pending.pop_front();
    if (d[1:0] !== r.status) begin
      $error("status exp %0d got %0d", r.status, d[1:0]); errors++;
    end
    if (d[17:2] !== r.pri) begin
      $error("removed_priority exp %0d got %0d", r.pri, d[17:2]); errors++;
    end
    if (d[33:18] !== r.tag) begin
      $error("removed_tag exp %0d got %0d", r.tag, d[33:18]); errors++;
    end
    if (d[42:34] !== r.occ) begin
      $error("occupancy exp %0d got %0d", r.occ, d[42:34]); errors++;
    end
  endfunction
endclass

module tb_top;
  localparam int CYCLE_LIMIT = 1500000;
  // Operation code with no meaning; the block must answer it as a no-op.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;

  depq_scoreboard book;
  int unsigned    cycles = 0;
  bit             hold_rx = 1'b0;  // long receiver stall request
  bit             stim_done = 1'b0;

  double_ended_priority_queue_unit dut (.*);

  always #5 clk = ~clk;

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Send one operation; wait a random gap first, then hold until accepted.
  // Valid stays high after acceptance until the next falling edge.
  task automatic send_op(logic [1:0] op, logic [15:0] tag, logic [15:0] pri);
    int gap;
    gap = (($urandom & 3) == 0) ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata <= {6'b0, pri, tag, op};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    book.note_op(op, tag, pri);
  endtask

  // Receiver: random stalls, plus a long hold when requested.
  initial begin
    int stall;
    forever begin
      @(negedge clk);
      if (hold_rx) begin
        out_tready <= 1'b0;
      end else begin
        stall = (($urandom & 3) == 0) ? 0 : $urandom_range(0, 15);
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
        out_tready <= 1'b1;
        do @(posedge clk); while (!out_tvalid);
        book.check_result(out_tdata);
      end
    end
  end

  // Pressure: hold the receiver off for a long stretch mid-run.
  initial begin
    wait (stim_done == 1'b0 && cycles > 3000);
    hold_rx = 1'b1;
    repeat (400) @(posedge clk);
    hold_rx = 1'b0;
  end

  initial begin
    int  k, mode;
    logic [1:0] op;
    book = new();
    book.clear();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty pops, field extremes, ties, unused code.
    send_op(depq_pkg::OP_POP_MAX, 16'hFFFF, 16'hFFFF);
    send_op(depq_pkg::OP_POP_MIN, 16'h0000, 16'h0000);
    send_op(depq_pkg::OP_INSERT, 16'h0000, 16'h0000);
    send_op(depq_pkg::OP_INSERT, 16'hFFFF, 16'hFFFF);
    send_op(depq_pkg::OP_INSERT, 16'h1234, 16'h8000);
    send_op(depq_pkg::OP_INSERT, 16'h5678, 16'h8000);
    send_op(depq_pkg::OP_INSERT, 16'hAAAA, 16'h5555);
    send_op(OP_UNUSED, 16'hFFFF, 16'hFFFF);
    send_op(depq_pkg::OP_POP_MAX, 16'h0000, 16'h0000);
    send_op(depq_pkg::OP_POP_MIN, 16'h0000, 16'h0000);
    send_op(depq_pkg::OP_POP_MAX, 16'h0000, 16'h0000);
    send_op(depq_pkg::OP_POP_MIN, 16'h0000, 16'h0000);
    send_op(depq_pkg::OP_POP_MAX, 16'h0000, 16'h0000);
    send_op(depq_pkg::OP_POP_MIN, 16'h0000, 16'h0000);

    // Fill to capacity, overflow, then drain mixed.
    for (k = 0; k < 258; k++)
      send_op(depq_pkg::OP_INSERT, 16'($urandom), 16'($urandom));
    for (k = 0; k < 258; k++)
      send_op(($urandom & 1) ? depq_pkg::OP_POP_MAX : depq_pkg::OP_POP_MIN,
              16'($urandom), 16'($urandom));

    // Random mix with drifting insert bias to sweep occupancy.
    for (k = 0; k < 1400; k++) begin
      mode = (k / 200) % 3;
      case ($urandom_range(0, 19))
        0: op = OP_UNUSED;
        1, 2, 3, 4, 5, 6, 7, 8: op = depq_pkg::OP_INSERT;
        9, 10, 11, 12: op = depq_pkg::OP_POP_MAX;
        13, 14, 15, 16: op = depq_pkg::OP_POP_MIN;
        default: op = (mode == 0) ? depq_pkg::OP_INSERT :
                      (mode == 1) ? depq_pkg::OP_POP_MIN : depq_pkg::OP_POP_MAX;
      endcase
      // Narrow priorities often so ties occur.
      send_op(op, 16'($urandom),
              16'(($urandom & 1) ? $urandom_range(0, 7) : $urandom));
    end
    @(negedge clk);
    in_tvalid <= 1'b0;
    stim_done = 1'b1;

    while (book.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (book.errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule

// ===== double_ended_priority_queue_unit.f =====
hdl/depq_pkg.sv
hdl/depq_heap_ram.sv
hdl/double_ended_priority_queue_unit.sv
hdl/depq_checker.sv
tb/tb_top.sv
